>>> rtl/anmm_pkg.sv
// ----------------------------------------------------------------------------
// anmm_pkg
// Types, constants and helpers shared by the adapter name/MAC matcher.
// ----------------------------------------------------------------------------
package anmm_pkg;

	localparam int NAME_LEN    = 32;
	localparam int MAC_LEN     = 18;
	localparam int MAX_DEVICES = 256;

	localparam int POS_W = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
	localparam int CNT_W = $clog2(MAX_DEVICES + 1);
	localparam int IDX_W = 8;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DEL   = 8'h7F;
	localparam logic [7:0] CHAR_LC_A  = 8'h61;
	localparam logic [7:0] CHAR_LC_Z  = 8'h7A;

	// configuration register indexes
	localparam logic [2:0] CFG_NAME_W0 = 3'd0;
	localparam logic [2:0] CFG_NAME_W1 = 3'd1;
	localparam logic [2:0] CFG_NAME_W2 = 3'd2;
	localparam logic [2:0] CFG_NAME_W3 = 3'd3;
	localparam logic [2:0] CFG_MAC_W0  = 3'd4;
	localparam logic [2:0] CFG_MAC_W1  = 3'd5;
	localparam logic [2:0] CFG_MAC_W2  = 3'd6;

	typedef enum logic [1:0] {
		CMP_UNDECIDED = 2'd0,
		CMP_EQUAL     = 2'd1,
		CMP_DIFFER    = 2'd2
	} cmp_t;

	typedef enum logic [2:0] {
		ST_FOUND          = 3'd0,
		ST_NO_DEVICES     = 3'd1,
		ST_NO_TARGET      = 3'd2,
		ST_MAC_NOT_FOUND  = 3'd3,
		ST_NAME_NOT_FOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic nul_seen;
		logic bytes_ok;
		cmp_t cmp;
	} field_state_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] device_index;
		logic             truncated;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0] device_count;
		logic             winner_valid;
	} list_state_t;

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= CHAR_LC_A && c <= CHAR_LC_Z) ? c - CHAR_SPACE : c;
	endfunction

endpackage

>>> rtl/anmm_field_track.sv
// ----------------------------------------------------------------------------
// anmm_field_track
// Per-device tracker for one text field: nul seen, printable check and the
// running case-blind compare against the target.
// ----------------------------------------------------------------------------
module anmm_field_track
	import anmm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         clr,
	input  logic [7:0]   c,
	input  logic [7:0]   t,
	output field_state_t nxt
);

	field_state_t cur_q;
	field_state_t upd;

	always_comb begin
		upd = cur_q;
		if (!cur_q.nul_seen) begin
			if (c == 8'h00)
				upd.nul_seen = 1'b1;
			else if (c < CHAR_SPACE || c >= CHAR_DEL)
				upd.bytes_ok = 1'b0;
		end
		if (cur_q.cmp == CMP_UNDECIDED) begin
			if (to_upper(c) != to_upper(t))
				upd.cmp = CMP_DIFFER;
			else if (c == 8'h00)
				upd.cmp = CMP_EQUAL;
		end
	end

	assign nxt = en ? upd : cur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.nul_seen <= 1'b0;
			cur_q.bytes_ok <= 1'b1;
			cur_q.cmp      <= CMP_UNDECIDED;
		end else if (clr) begin
			cur_q.nul_seen <= 1'b0;
			cur_q.bytes_ok <= 1'b1;
			cur_q.cmp      <= CMP_UNDECIDED;
		end else if (en) begin
			cur_q <= upd;
		end
	end

endmodule

>>> rtl/anmm_select.sv
// ----------------------------------------------------------------------------
// anmm_select
// Device judging, winner bookkeeping and end-of-list status.
// ----------------------------------------------------------------------------
module anmm_select
	import anmm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              judge,
	input  logic              eol,
	input  logic signed [7:0] rssi,
	input  field_state_t      name_st,
	input  field_state_t      mac_st,
	input  logic              mac_set,
	input  logic              name_set,
	output result_t           res,
	output list_state_t       lst
);

	logic [CNT_W-1:0]  device_count_q;
	logic              winner_valid_q;
	logic [IDX_W-1:0]  winner_index_q;
	logic signed [7:0] winner_rssi_q;
	logic              overflow_q;

	logic full;
	logic usable;
	logic take;

	assign full   = device_count_q >= CNT_W'(MAX_DEVICES);
	assign usable = name_st.nul_seen && mac_st.nul_seen && name_st.bytes_ok && mac_st.bytes_ok;

	always_comb begin
		take = 1'b0;
		if (usable) begin
			if (mac_set)
				take = (mac_st.cmp == CMP_EQUAL) && !winner_valid_q;
			else if (name_st.cmp == CMP_EQUAL)
				take = !winner_valid_q || (rssi > winner_rssi_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_count_q <= '0;
			winner_valid_q <= 1'b0;
			winner_index_q <= '0;
			winner_rssi_q  <= '0;
			overflow_q     <= 1'b0;
		end else if (eol) begin
			device_count_q <= '0;
			winner_valid_q <= 1'b0;
			winner_index_q <= '0;
			winner_rssi_q  <= '0;
			overflow_q     <= 1'b0;
		end else if (judge) begin
			if (full) begin
				overflow_q <= 1'b1;
			end else begin
				device_count_q <= device_count_q + 1'b1;
				if (take) begin
					winner_valid_q <= 1'b1;
					winner_index_q <= IDX_W'(device_count_q);
					winner_rssi_q  <= rssi;
				end
			end
		end
	end

	always_comb begin
		res.device_index = '0;
		res.truncated    = overflow_q;
		if (device_count_q == '0)
			res.status = ST_NO_DEVICES;
		else if (!mac_set && !name_set)
			res.status = ST_NO_TARGET;
		else if (winner_valid_q) begin
			res.status       = ST_FOUND;
			res.device_index = winner_index_q;
		end else if (mac_set)
			res.status = ST_MAC_NOT_FOUND;
		else
			res.status = ST_NAME_NOT_FOUND;
	end

	assign lst.device_count = device_count_q;
	assign lst.winner_valid = winner_valid_q;

endmodule

>>> rtl/adapter_name_mac_matcher.sv
// ----------------------------------------------------------------------------
// adapter_name_mac_matcher
// Picks one adapter from a streamed device list by case-blind name or MAC
// text match and reports the outcome on each end-of-list request.
// ----------------------------------------------------------------------------
// Result path: an end-of-list request is registered in the input stage and,
//   once it advances, loads the result register that drives m_tvalid.
// Throughput: one request per cycle; the single result register stalls the
//   input stage only when an end-of-list request meets an untaken result.
// Reset: arst_n clears list state, target registers and both valid flags.
module adapter_name_mac_matcher
	import anmm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // name_char[7:0], mac_char[15:8], rssi[23:16]
	input  logic        s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // status[2:0], device_index[10:3], list_truncated[11]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] name_w_q [4];
	logic [63:0] mac_w_q  [3];

	logic              valid_s1;
	logic              kind_s1;
	logic [7:0]        name_s1;
	logic [7:0]        mac_s1;
	logic signed [7:0] rssi_s1;

	logic [POS_W-1:0] position_q;
	logic             out_valid_q;
	result_t          out_q;

	logic         advance;
	logic         step;
	logic         eol;
	logic         last_pos;
	logic         dev_done;
	logic         mac_en;
	logic [255:0] name_tgt;
	logic [191:0] mac_tgt;
	logic [4:0]   mac_byte_idx;
	logic [7:0]   name_t;
	logic [7:0]   mac_t;
	logic         mac_set;
	logic         name_set;
	field_state_t name_st;
	field_state_t mac_st;
	result_t      res;
	list_state_t  lst;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) name_w_q[i] <= '0;
			for (int i = 0; i < 3; i++) mac_w_q[i] <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_NAME_W0: name_w_q[0] <= cfg_data;
				CFG_NAME_W1: name_w_q[1] <= cfg_data;
				CFG_NAME_W2: name_w_q[2] <= cfg_data;
				CFG_NAME_W3: name_w_q[3] <= cfg_data;
				CFG_MAC_W0:  mac_w_q[0]  <= cfg_data;
				CFG_MAC_W1:  mac_w_q[1]  <= cfg_data;
				CFG_MAC_W2:  mac_w_q[2]  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign name_tgt = {name_w_q[3], name_w_q[2], name_w_q[1], name_w_q[0]};
	assign mac_tgt  = {mac_w_q[2], mac_w_q[1], mac_w_q[0]};
	assign mac_set  = mac_w_q[0][7:0] != 8'h00;
	assign name_set = name_w_q[0][7:0] != 8'h00;

	// input stage
	assign advance  = valid_s1 && !(kind_s1 && out_valid_q && !m_tready);
	assign s_tready = !valid_s1 || advance;
	assign step     = advance && !kind_s1;
	assign eol      = advance && kind_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			name_s1 <= s_tdata[7:0];
			mac_s1  <= s_tdata[15:8];
			rssi_s1 <= s_tdata[23:16];
		end
	end

	// byte position within the current device
	assign last_pos = position_q == POS_W'(NAME_LEN - 1);
	assign dev_done = step && last_pos;
	assign mac_en   = step && (32'(position_q) < MAC_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			position_q <= '0;
		else if (eol || dev_done)
			position_q <= '0;
		else if (step)
			position_q <= position_q + 1'b1;
	end

	// past the MAC length the byte is unused, so keep the select in range
	assign mac_byte_idx = (32'(position_q) < MAC_LEN) ? 5'(position_q) : 5'd0;
	assign name_t       = name_tgt[{position_q, 3'b000} +: 8];
	assign mac_t        = mac_tgt[{mac_byte_idx, 3'b000} +: 8];

	anmm_field_track u_name_track (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (step),
		.clr    (eol || dev_done),
		.c      (name_s1),
		.t      (name_t),
		.nxt    (name_st)
	);

	anmm_field_track u_mac_track (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (mac_en),
		.clr    (eol || dev_done),
		.c      (mac_s1),
		.t      (mac_t),
		.nxt    (mac_st)
	);

	anmm_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.judge    (dev_done),
		.eol      (eol),
		.rssi     (rssi_s1),
		.name_st  (name_st),
		.mac_st   (mac_st),
		.mac_set  (mac_set),
		.name_set (name_set),
		.res      (res),
		.lst      (lst)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (eol)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (eol)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_q.truncated, out_q.device_index, out_q.status};

	// checks
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(position_q) < NAME_LEN)
		else $error("position beyond device length");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(lst.device_count) <= MAX_DEVICES)
		else $error("device count beyond limit");

	a_winner_counted: assert property (@(posedge clk) disable iff (!arst_n)
		lst.winner_valid |-> lst.device_count != '0)
		else $error("winner without counted device");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !$past(m_tvalid)) |-> $past(valid_s1 && kind_s1))
		else $error("result without end-of-list request");

endmodule
